// ===== hw/rtl/pae_pkg.sv =====
// positional array engine package: sizes, operation codes, cell control
// and reduction leaf types, and the min/max/read merge function
// no dependencies
package pae_pkg;

  localparam int DEPTH  = 64;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int POS_W  = 6;
  localparam int DATA_W = 32;
  localparam int RED_N  = 8;
  localparam int GROUPS = DEPTH / RED_N;

  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(64);

  typedef enum logic [2:0] {
    OP_APPEND  = 3'd0,
    OP_INSERT  = 3'd1,
    OP_REMOVE  = 3'd2,
    OP_REVERSE = 3'd3,
    OP_READ    = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    CM_HOLD,
    CM_INS,
    CM_DEL
  } cmode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RED1,
    ST_RED2,
    ST_OUT
  } state_t;

  typedef struct packed {
    cmode_t             mode;
    logic [CNT_W-1:0]   k;
    logic [DATA_W-1:0]  val;
  } cell_ctl_t;

  typedef struct packed {
    logic                     live;
    logic signed [DATA_W-1:0] mn;
    logic signed [DATA_W-1:0] mx;
    logic [DATA_W-1:0]        rd;
  } leaf_t;

  function automatic leaf_t leaf_merge(leaf_t a, leaf_t b);
    leaf_t r;
    r.live = a.live | b.live;
    r.rd   = a.rd | b.rd;
    if (a.live && b.live) begin
      r.mn = (b.mn < a.mn) ? b.mn : a.mn;
      r.mx = (b.mx > a.mx) ? b.mx : a.mx;
    end else if (a.live) begin
      r.mn = a.mn;
      r.mx = a.mx;
    end else begin
      r.mn = b.mn;
      r.mx = b.mx;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/positional_array_engine.sv =====
// positional array engine top level: op decode, control sequencer, cell
// chain and two-stage min/max/read reduction tree
// depends on pae_pkg, pae_cell, pae_red8
//
// usage:
//   input channel (in_valid/in_stall) carries operation, position, value.
//   result channel (out_valid/out_stall) returns one result per input
//   transfer: accepted flag, count, read value, min, max and empty flag.
//   cfg_capacity is written through cfg_valid/cfg_ready, always ready,
//   and should only be written while no item is in flight.
// sequencing:
//   out_valid rises once the input has passed the control register, the cell
//   shift and two registered min/max tree levels. the next input is taken in
//   the cycle the result transfers, so each item completes before the next.
// reset:
//   count clears to zero, capacity to 64, no result pending. cell contents
//   are not cleared; only live cells are ever read.
// stall:
//   a stalled result holds its payload; no input is taken until it moves.
//   reverse flips a direction flag, so stored words never move for it.
module positional_array_engine
  import pae_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [2:0]               in_operation,
  input  logic [POS_W-1:0]         in_position,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_accepted,
  output logic [CNT_W-1:0]         out_count,
  output logic signed [DATA_W-1:0] out_read_value,
  output logic signed [DATA_W-1:0] out_minimum,
  output logic signed [DATA_W-1:0] out_maximum,
  output logic                     out_empty_res,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CNT_W-1:0]         cfg_capacity
);

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  cap_r;
  logic              rev_r, rev_nxt;
  logic              acc_r, acc_nxt;
  logic              rd_en_r, rd_en_nxt;
  logic [CNT_W-1:0]  rd_k_r, rd_k_nxt;
  cell_ctl_t         ctl_r, ctl_nxt;

  logic              in_xfer;
  logic              out_xfer;
  logic [CNT_W-1:0]  lim;
  logic [CNT_W-1:0]  pos_w;
  logic              full;
  logic              pos_ok;

  logic [DATA_W-1:0] cell_q [DEPTH];
  leaf_t             leaves [DEPTH];
  leaf_t             grp_in [GROUPS][RED_N];
  leaf_t             grp_res [GROUPS];
  leaf_t             top_res;

  assign cfg_ready = 1'b1;
  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid && !out_stall;

  // request decode
  always_comb begin
    lim    = (cap_r < CNT_W'(DEPTH)) ? cap_r : CNT_W'(DEPTH);
    pos_w  = CNT_W'(in_position);
    full   = count_r >= lim;
    pos_ok = pos_w < count_r;

    count_nxt   = count_r;
    rev_nxt     = rev_r;
    acc_nxt     = 1'b0;
    rd_en_nxt   = 1'b0;
    rd_k_nxt    = rev_r ? (count_r - pos_w - CNT_W'(1)) : pos_w;
    ctl_nxt.mode = CM_HOLD;
    ctl_nxt.k    = '0;
    ctl_nxt.val  = in_value;

    case (op_t'(in_operation))
      OP_APPEND: begin
        if (!full) begin
          ctl_nxt.mode = CM_INS;
          ctl_nxt.k    = rev_r ? '0 : count_r;
          count_nxt    = count_r + CNT_W'(1);
          acc_nxt      = 1'b1;
        end
      end
      OP_INSERT: begin
        if (pos_ok && !full) begin
          ctl_nxt.mode = CM_INS;
          ctl_nxt.k    = rev_r ? (count_r - pos_w) : pos_w;
          count_nxt    = count_r + CNT_W'(1);
          acc_nxt      = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (pos_ok) begin
          ctl_nxt.mode = CM_DEL;
          ctl_nxt.k    = rd_k_nxt;
          count_nxt    = count_r - CNT_W'(1);
          acc_nxt      = 1'b1;
        end
      end
      OP_REVERSE: begin
        rev_nxt = !rev_r;
        acc_nxt = 1'b1;
      end
      OP_READ: begin
        if (pos_ok) begin
          rd_en_nxt = 1'b1;
          acc_nxt   = 1'b1;
        end
      end
      default: acc_nxt = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_xfer) state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = ST_RED1;
      ST_RED1: state_nxt = ST_RED2;
      ST_RED2: state_nxt = ST_OUT;
      ST_OUT: begin
        if (in_xfer) begin
          state_nxt = ST_EXEC;
        end else if (out_xfer) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    out_valid = 1'b0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: in_stall = 1'b0;
      ST_OUT: begin
        out_valid = 1'b1;
        in_stall  = out_stall;
      end
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      cap_r   <= CAP_RESET;
      rev_r   <= 1'b0;
      ctl_r.mode <= CM_HOLD;
      acc_r   <= 1'b0;
      rd_en_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_capacity;
      end
      if (in_xfer) begin
        count_r    <= count_nxt;
        rev_r      <= rev_nxt;
        acc_r      <= acc_nxt;
        rd_en_r    <= rd_en_nxt;
        ctl_r.mode <= ctl_nxt.mode;
        ctl_r.k    <= ctl_nxt.k;
        ctl_r.val  <= ctl_nxt.val;
      end else begin
        ctl_r.mode <= CM_HOLD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      rd_k_r    <= rd_k_nxt;
    end
  end

  // cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] left_q;
    logic [DATA_W-1:0] right_q;

    if (i == 0) begin : g_first
      assign left_q = '0;
    end else begin : g_mid_l
      assign left_q = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_q = '0;
    end else begin : g_mid_r
      assign right_q = cell_q[i+1];
    end

    pae_cell u_cell (
      .clk     (clk),
      .idx     (CNT_W'(i)),
      .ctl     (ctl_r),
      .left_q  (left_q),
      .right_q (right_q),
      .q       (cell_q[i])
    );

    assign leaves[i].live = CNT_W'(i) < count_r;
    assign leaves[i].mn   = cell_q[i];
    assign leaves[i].mx   = cell_q[i];
    assign leaves[i].rd   = (rd_en_r && (rd_k_r == CNT_W'(i))) ? cell_q[i] : '0;
  end

  // reduction tree
  for (genvar g = 0; g < GROUPS; g++) begin : g_grp
    for (genvar j = 0; j < RED_N; j++) begin : g_leaf
      assign grp_in[g][j] = leaves[g*RED_N + j];
    end

    pae_red8 u_red (
      .clk    (clk),
      .leaves (grp_in[g]),
      .res    (grp_res[g])
    );
  end

  pae_red8 u_red_top (
    .clk    (clk),
    .leaves (grp_res),
    .res    (top_res)
  );

  assign out_accepted   = acc_r;
  assign out_count      = count_r;
  assign out_empty_res  = count_r == '0;
  assign out_read_value = top_res.rd;
  assign out_minimum    = top_res.live ? top_res.mn : '0;
  assign out_maximum    = top_res.live ? top_res.mx : '0;

`ifndef SYNTHESIS
  a_in_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |-> (state_r == ST_IDLE || state_r == ST_OUT))
    else $error("input transfer while an item is in flight");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_empty_res) |-> (out_minimum == '0 && out_maximum == '0))
    else $error("empty result with nonzero min or max");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_count <= CNT_W'(DEPTH)))
    else $error("count beyond depth");

  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_xfer |=> $stable(count_r))
    else $error("count changed without an input transfer");
`endif

endmodule

// ===== hw/rtl/pae_cell.sv =====
// one storage cell of the array chain: holds one word, takes its left
// neighbor on an insert shift, its right neighbor on a remove shift
// depends on pae_pkg
module pae_cell
  import pae_pkg::*;
(
  input  logic              clk,
  input  logic [CNT_W-1:0]  idx,
  input  cell_ctl_t         ctl,
  input  logic [DATA_W-1:0] left_q,
  input  logic [DATA_W-1:0] right_q,
  output logic [DATA_W-1:0] q
);

  logic [DATA_W-1:0] q_r;
  logic [DATA_W-1:0] q_nxt;

  always_comb begin
    q_nxt = q_r;
    case (ctl.mode)
      CM_INS: begin
        if (idx > ctl.k) begin
          q_nxt = left_q;
        end else if (idx == ctl.k) begin
          q_nxt = ctl.val;
        end
      end
      CM_DEL: begin
        if (idx >= ctl.k) begin
          q_nxt = right_q;
        end
      end
      default: q_nxt = q_r;
    endcase
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

// ===== hw/rtl/pae_red8.sv =====
// registered eight-input reduction node: min and max over live leaves,
// read select over all leaves, three merge levels then a register
// depends on pae_pkg
module pae_red8
  import pae_pkg::*;
(
  input  logic  clk,
  input  leaf_t leaves [RED_N],
  output leaf_t res
);

  leaf_t lvl1 [4];
  leaf_t lvl2 [2];
  leaf_t res_r;
  leaf_t res_nxt;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      lvl1[i] = leaf_merge(leaves[2*i], leaves[2*i+1]);
    end
    for (int i = 0; i < 2; i++) begin
      lvl2[i] = leaf_merge(lvl1[2*i], lvl1[2*i+1]);
    end
    res_nxt = leaf_merge(lvl2[0], lvl2[1]);
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res = res_r;

endmodule
